@@ design/pgc_pkg.sv @@
// Shared types and constants for the pointer gesture classifier.
// No dependencies; every other design file imports this package.
package pgc_pkg;

    // Input command codes (carried on s_tuser).
    localparam logic [1:0] CMD_PRESS   = 2'd0;
    localparam logic [1:0] CMD_DBL     = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;
    localparam logic [1:0] CMD_MOTION  = 2'd3;

    // Result event codes (carried on m_tuser).
    localparam logic [2:0] EV_MOVE       = 3'd0;
    localparam logic [2:0] EV_DOWN       = 3'd1;
    localparam logic [2:0] EV_UP         = 3'd2;
    localparam logic [2:0] EV_CLICK      = 3'd3;
    localparam logic [2:0] EV_DBL_CLICK  = 3'd4;
    localparam logic [2:0] EV_START_DRAG = 3'd5;
    localparam logic [2:0] EV_DRAG       = 3'd6;
    localparam logic [2:0] EV_END_DRAG   = 3'd7;

    // Button classes.
    localparam logic [1:0] CLS_LEFT  = 2'd0;
    localparam logic [1:0] CLS_MID   = 2'd1;
    localparam logic [1:0] CLS_RIGHT = 2'd2;
    localparam logic [1:0] CLS_LR    = 2'd3;

    // Tracked button numbers.
    localparam logic [2:0] BTN_LEFT  = 3'd1;
    localparam logic [2:0] BTN_MID   = 3'd2;
    localparam logic [2:0] BTN_RIGHT = 3'd3;

    localparam int BTN_W   = 3;
    localparam int MODS_W  = 13;
    localparam int KIND_W  = 3;
    localparam int CLS_W   = 2;
    localparam int DIST_W  = 8;
    localparam int HELD_W  = 8;

    localparam logic [DIST_W-1:0] DRAG_DISTANCE_RESET = 8'd4;

    // Register indexes of the configuration port.
    localparam logic REG_DRAG_DISTANCE = 1'b0;

    // Result queue depth; an item is taken only when two entries are free.
    localparam int RQ_DEPTH = 4;

    // Results written to the queue by one evaluated item.
    typedef struct packed {
        logic first;
        logic second;
    } pgc_push_t;

endpackage

@@ design/pgc_apb_regs.sv @@
// Configuration register file on an APB-style port.
// Holds the drag distance threshold; uses pgc_pkg.
module pgc_apb_regs
    import pgc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic [DIST_W-1:0] drag_distance
);

    logic [DIST_W-1:0] drag_distance_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drag_distance_reg <= DRAG_DISTANCE_RESET;
        end else if (wr_en && (paddr[2] == REG_DRAG_DISTANCE)) begin
            drag_distance_reg <= pwdata[DIST_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_DRAG_DISTANCE) begin
            prdata = {{(32-DIST_W){1'b0}}, drag_distance_reg};
        end
    end

    assign drag_distance = drag_distance_reg;

endmodule

@@ design/pgc_core.sv @@
// Input register, gesture state and combinational event classification.
// Produces up to two packed results per item; uses pgc_pkg.
module pgc_core
    import pgc_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int RES_W      = 1 + KIND_W + CLS_W + MODS_W + 6 * COORD_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   in_cmd,
    input  logic [BTN_W-1:0]             in_button,
    input  logic [MODS_W-1:0]            in_mods,
    input  logic signed [COORD_BITS-1:0] in_x,
    input  logic signed [COORD_BITS-1:0] in_y,
    input  logic [DIST_W-1:0]            drag_distance,
    input  logic                         space_ok,
    output pgc_push_t                    push,
    output logic [RES_W-1:0]             res0,
    output logic [RES_W-1:0]             res1
);

    localparam int CB = COORD_BITS;

    // Registered input item.
    logic                 item_valid_reg;
    logic [1:0]           cmd_reg;
    logic [BTN_W-1:0]     button_reg;
    logic [MODS_W-1:0]    mods_reg;
    logic signed [CB-1:0] px_reg, py_reg;

    // Gesture state.
    logic [HELD_W-1:0]    held_mask_reg, held_mask_next;
    logic                 dragging_reg, dragging_next;
    logic signed [CB-1:0] start_x_reg, start_y_reg, start_x_next, start_y_next;
    logic signed [CB-1:0] prev_x_reg, prev_y_reg, prev_x_next, prev_y_next;
    logic signed [CB-1:0] curr_x_reg, curr_y_reg;

    logic consume;

    assign consume  = item_valid_reg && space_ok;
    assign in_ready = !item_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (in_ready) begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            cmd_reg    <= in_cmd;
            button_reg <= in_button;
            mods_reg   <= in_mods;
            px_reg     <= in_x;
            py_reg     <= in_y;
        end
    end

    // Distance test against the start point, using the new position.
    logic signed [CB:0] dx_s, dy_s;
    logic [CB:0]        dx, dy;
    logic [15:0]        dx_sq, dy_sq, dd_sq;
    logic [16:0]        dist_sq;
    logic               beyond;

    always_comb begin
        dx_s  = {px_reg[CB-1], px_reg} - {start_x_reg[CB-1], start_x_reg};
        dy_s  = {py_reg[CB-1], py_reg} - {start_y_reg[CB-1], start_y_reg};
        dx    = dx_s[CB] ? $unsigned(-dx_s) : $unsigned(dx_s);
        dy    = dy_s[CB] ? $unsigned(-dy_s) : $unsigned(dy_s);
        dx_sq = dx[7:0] * dx[7:0];
        dy_sq = dy[7:0] * dy[7:0];
        dd_sq = drag_distance * drag_distance;
        dist_sq = {1'b0, dx_sq} + {1'b0, dy_sq};
        // Any component above 255 is always past the largest threshold.
        beyond = (|dx[CB:8]) || (|dy[CB:8]) || (dist_sq > {1'b0, dd_sq});
    end

    // Button classes.
    logic       held_any;
    logic       single_v, held_v;
    logic [1:0] single_cls, held_cls;

    always_comb begin
        held_any   = |held_mask_reg;
        single_v   = (button_reg == BTN_LEFT) || (button_reg == BTN_MID) ||
                     (button_reg == BTN_RIGHT);
        single_cls = 2'(button_reg - 3'd1);
        held_v     = 1'b1;
        if (held_mask_reg[BTN_LEFT] && held_mask_reg[BTN_RIGHT]) begin
            held_cls = CLS_LR;
        end else if (held_mask_reg[BTN_LEFT]) begin
            held_cls = CLS_LEFT;
        end else if (held_mask_reg[BTN_MID]) begin
            held_cls = CLS_MID;
        end else if (held_mask_reg[BTN_RIGHT]) begin
            held_cls = CLS_RIGHT;
        end else begin
            held_cls = CLS_LEFT;
            held_v   = 1'b0;
        end
    end

    // Candidate results: A is the first event of the item, B the second.
    logic             a_v, b_v, a_path, b_path;
    logic [KIND_W-1:0] a_kind, b_kind;
    logic [CLS_W-1:0] a_cls, b_cls;
    logic [CB-1:0]    a_px, a_py, b_px, b_py;

    always_comb begin
        a_v    = 1'b0;
        b_v    = 1'b0;
        a_path = 1'b0;
        b_path = 1'b0;
        a_kind = EV_MOVE;
        b_kind = EV_CLICK;
        a_cls  = single_cls;
        b_cls  = single_cls;
        a_px   = prev_x_reg;
        a_py   = prev_y_reg;
        b_px   = prev_x_reg;
        b_py   = prev_y_reg;
        held_mask_next = held_mask_reg;
        dragging_next  = dragging_reg;
        start_x_next   = start_x_reg;
        start_y_next   = start_y_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        unique case (cmd_reg)
            CMD_PRESS: begin
                if (!held_any) begin
                    start_x_next = px_reg;
                    start_y_next = py_reg;
                    prev_x_next  = px_reg;
                    prev_y_next  = py_reg;
                end
                held_mask_next = held_mask_reg | (HELD_W'(1) << button_reg);
                a_v    = single_v;
                a_kind = EV_DOWN;
            end
            CMD_DBL: begin
                a_v    = single_v;
                a_kind = EV_DBL_CLICK;
                held_mask_next = '0;
                dragging_next  = 1'b0;
            end
            CMD_MOTION: begin
                prev_x_next = curr_x_reg;
                prev_y_next = curr_y_reg;
                a_px  = curr_x_reg;
                a_py  = curr_y_reg;
                a_cls = held_cls;
                if (dragging_reg) begin
                    a_v    = held_v;
                    a_kind = EV_DRAG;
                    a_path = 1'b1;
                end else if (held_any) begin
                    if (beyond) begin
                        dragging_next = 1'b1;
                        a_v    = held_v;
                        a_kind = EV_START_DRAG;
                    end
                end else begin
                    a_v    = 1'b1;
                    a_kind = EV_MOVE;
                    a_cls  = CLS_LEFT;
                end
            end
            CMD_RELEASE: begin
                a_v    = single_v;
                a_kind = EV_UP;
                if (held_any) begin
                    if (dragging_reg) begin
                        b_v    = held_v;
                        b_kind = EV_END_DRAG;
                        b_cls  = held_cls;
                        b_path = 1'b1;
                    end else begin
                        b_v    = single_v;
                        b_kind = EV_CLICK;
                    end
                    held_mask_next = '0;
                    dragging_next  = 1'b0;
                end
            end
            default: begin
                a_v = 1'b0;
            end
        endcase
    end

    // Pack the results: {last, kind, origin_y, origin_x, prev_y, prev_x,
    // cur_y, cur_x, modifiers, class}.
    logic [RES_W-1:0] pack_a, pack_b;

    always_comb begin
        pack_a = {1'b0, a_kind,
                  a_path ? start_y_reg : CB'(0), a_path ? start_x_reg : CB'(0),
                  a_path ? a_py : CB'(0), a_path ? a_px : CB'(0),
                  py_reg, px_reg, mods_reg, a_cls};
        pack_b = {1'b1, b_kind,
                  b_path ? start_y_reg : CB'(0), b_path ? start_x_reg : CB'(0),
                  b_path ? b_py : CB'(0), b_path ? b_px : CB'(0),
                  py_reg, px_reg, mods_reg, b_cls};
        // The first result closes the run unless a second one follows.
        pack_a[RES_W-1] = !b_v;
        res0 = a_v ? pack_a : pack_b;
        res1 = pack_b;
        push.first  = consume && (a_v || b_v);
        push.second = consume && a_v && b_v;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_mask_reg <= '0;
            dragging_reg  <= 1'b0;
            start_x_reg   <= '0;
            start_y_reg   <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            curr_x_reg    <= '0;
            curr_y_reg    <= '0;
        end else if (consume) begin
            held_mask_reg <= held_mask_next;
            dragging_reg  <= dragging_next;
            start_x_reg   <= start_x_next;
            start_y_reg   <= start_y_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            curr_x_reg    <= px_reg;
            curr_y_reg    <= py_reg;
        end
    end

    // A drag can only be in progress while some button is held.
    a_drag_needs_held: assert property (@(posedge aclk) disable iff (!aresetn)
        dragging_reg |-> (held_mask_reg != '0))
        else $error("dragging set with no button held");

    // A double click leaves no held buttons and no drag.
    a_dbl_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && (cmd_reg == CMD_DBL)) |=> (held_mask_reg == '0) && !dragging_reg)
        else $error("double click did not clear the gesture state");

    // Results are only written while the queue has room for two.
    a_push_space: assert property (@(posedge aclk) disable iff (!aresetn)
        push.first |-> space_ok)
        else $error("result written without queue space");

endmodule

@@ design/pgc_result_fifo.sv @@
// Small result queue: takes up to two results per cycle and presents one
// output transfer per cycle while out_ready is high; uses pgc_pkg.
module pgc_result_fifo
    import pgc_pkg::*;
#(
    parameter int WIDTH = 112
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  pgc_push_t        push,
    input  logic [WIDTH-1:0] din0,
    input  logic [WIDTH-1:0] din1,
    output logic             space_ok,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] dout
);

    localparam int PTR_W = $clog2(RQ_DEPTH);
    localparam int CNT_W = $clog2(RQ_DEPTH + 1);

    logic [WIDTH-1:0] mem [RQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;
    logic [CNT_W-1:0] push_n;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign dout      = mem[rd_ptr_reg];
    assign space_ok  = (count_reg <= CNT_W'(RQ_DEPTH - 2));
    assign push_n    = CNT_W'(push.first) + CNT_W'(push.second);
    assign count_next = count_reg + push_n - CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (push.first) begin
            mem[wr_ptr_reg] <= din0;
        end
        if (push.second) begin
            mem[PTR_W'(wr_ptr_reg + PTR_W'(1))] <= din1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_n);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(pop);
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(RQ_DEPTH))
        else $error("result queue overflow");

    a_second_needs_first: assert property (@(posedge aclk) disable iff (!aresetn)
        push.second |-> push.first)
        else $error("second result written without a first");

endmodule

@@ design/pointer_gesture_classifier_unit.sv @@
// Pointer gesture classifier: turns press, double-click, release and motion
// events into move, down, up, click, double click and drag events. An input
// transfer is taken every cycle while the queue has room; it passes an input
// register, is classified combinationally against the gesture state and
// leaves one or two results in a four-entry result queue. The result side
// moves one transfer per cycle while m_tready is high, so an item that yields
// two results (a release) occupies it for two transfers; the input is held
// off while the queue has fewer than two free entries. An item that yields no
// result produces no output transfer. drag_distance is written at byte
// address 0 of the configuration port.
// Depends on pgc_pkg, pgc_apb_regs, pgc_core and pgc_result_fifo.
module pointer_gesture_classifier_unit
    import pgc_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: button[2:0], modifiers[15:3], pos_x, pos_y, zero padding
    input  logic [((BTN_W + MODS_W + 2 * COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // tuser: cmd
    input  logic [1:0]  s_tuser,
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: button_class[1:0], event_modifiers[14:2], cur_x, cur_y, prev_x,
    // prev_y, origin_x, origin_y, zero padding
    output logic [((CLS_W + MODS_W + 6 * COORD_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    // tuser: event_kind
    output logic [KIND_W-1:0] m_tuser,
    output logic        m_tlast,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CB      = COORD_BITS;
    localparam int PAY_W   = CLS_W + MODS_W + 6 * CB;
    localparam int RES_W   = 1 + KIND_W + PAY_W;
    localparam int M_DATA_W = ((PAY_W + 7) / 8) * 8;

    logic [DIST_W-1:0] drag_distance;
    logic              space_ok;
    pgc_push_t         push;
    logic [RES_W-1:0]  res0, res1, res_out;

    pgc_apb_regs u_regs (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .drag_distance (drag_distance)
    );

    pgc_core #(
        .COORD_BITS (CB),
        .RES_W      (RES_W)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_cmd        (s_tuser),
        .in_button     (s_tdata[BTN_W-1:0]),
        .in_mods       (s_tdata[BTN_W+MODS_W-1:BTN_W]),
        .in_x          (s_tdata[BTN_W+MODS_W+CB-1:BTN_W+MODS_W]),
        .in_y          (s_tdata[BTN_W+MODS_W+2*CB-1:BTN_W+MODS_W+CB]),
        .drag_distance (drag_distance),
        .space_ok      (space_ok),
        .push          (push),
        .res0          (res0),
        .res1          (res1)
    );

    pgc_result_fifo #(
        .WIDTH (RES_W)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .din0      (res0),
        .din1      (res1),
        .space_ok  (space_ok),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .dout      (res_out)
    );

    assign m_tlast = res_out[RES_W-1];
    assign m_tuser = res_out[RES_W-2:PAY_W];
    assign m_tdata = M_DATA_W'(res_out[PAY_W-1:0]);

endmodule

@@ bench/tb_pointer_gesture_classifier_unit.sv @@
// Self-checking bench for pointer_gesture_classifier_unit: streams pointer events in, predicts
// the gesture results with a behavioural model of its own and checks every result transfer.
// Depends on pgc_pkg and the classifier RTL only.
`timescale 1ns / 100ps

module tb_pointer_gesture_classifier_unit;
    import pgc_pkg::*;

    localparam int CW           = 16;
    localparam int S_W          = ((BTN_W + MODS_W + 2 * CW + 7) / 8) * 8;
    localparam int M_W          = ((CLS_W + MODS_W + 6 * CW + 7) / 8) * 8;
    localparam int LIMIT_CYCLES = 300000;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 600;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [BTN_W-1:0]  button;
        logic [MODS_W-1:0] mods;
        logic [CW-1:0]     x;
        logic [CW-1:0]     y;
    } pointer_event_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CLS_W-1:0]  cls;
        logic [MODS_W-1:0] mods;
        logic [CW-1:0]     cur_x;
        logic [CW-1:0]     cur_y;
        logic [CW-1:0]     prev_x;
        logic [CW-1:0]     prev_y;
        logic [CW-1:0]     org_x;
        logic [CW-1:0]     org_y;
        logic              last;
    } gesture_event_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [S_W-1:0]    s_tdata  = '0;
    logic [1:0]        s_tuser  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [M_W-1:0]    m_tdata;
    logic [KIND_W-1:0] m_tuser;
    logic              m_tlast;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [2:0]        paddr    = '0;
    logic [31:0]       pwdata   = '0;
    logic [31:0]       prdata;
    logic              pready;

    pointer_gesture_classifier_unit #(.COORD_BITS(CW)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Bench-side copy of the gesture state and configuration.
    logic [DIST_W-1:0]  drag_dist = DRAG_DISTANCE_RESET;
    logic [HELD_W-1:0]  held      = '0;
    logic               dragging  = 1'b0;
    logic signed [CW-1:0] start_x = '0, start_y = '0;
    logic signed [CW-1:0] prev_x  = '0, prev_y  = '0;
    logic signed [CW-1:0] cur_x   = '0, cur_y   = '0;

    pointer_event_t pending_pointer_events[$];
    gesture_event_t expected_events[$];
    pointer_event_t offered_event;

    int send_idle_pct    = 0;
    int recv_stall_pct   = 0;
    int queued_count     = 0;
    int accepted_count   = 0;
    int checked_count    = 0;
    int error_count      = 0;
    int input_stall_cnt  = 0;
    int cycle_count      = 0;
    int hold_cycles      = 0;
    logic long_hold_armed = 1'b0;
    logic long_hold_done  = 1'b0;
    logic signed [CW-1:0] gx = '0, gy = '0;

    wire rx_held = long_hold_armed && !long_hold_done;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- predictor
    function automatic int single_class(logic [BTN_W-1:0] b);
        if (b >= BTN_LEFT && b <= BTN_RIGHT)
            return int'(b) - 1;
        return -1;
    endfunction

    function automatic int held_class();
        if (held[BTN_LEFT] && held[BTN_RIGHT]) return int'(CLS_LR);
        if (held[BTN_LEFT])                    return int'(CLS_LEFT);
        if (held[BTN_MID])                     return int'(CLS_MID);
        if (held[BTN_RIGHT])                   return int'(CLS_RIGHT);
        return -1;
    endfunction

    function automatic logic beyond_threshold();
        int dx, dy, lim;
        dx  = int'(cur_x) - int'(start_x);
        dy  = int'(cur_y) - int'(start_y);
        lim = int'(drag_dist);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        // Beyond 255 on one axis the distance can never be inside the threshold.
        if (dx > 255 || dy > 255)
            return 1'b1;
        return (dx * dx + dy * dy) > (lim * lim);
    endfunction

    function automatic gesture_event_t make_result(logic [KIND_W-1:0] kind, int cls,
                                                   logic [MODS_W-1:0] mods, logic path);
        gesture_event_t r;
        r.kind   = kind;
        r.cls    = CLS_W'(cls);
        r.mods   = mods;
        r.cur_x  = cur_x;
        r.cur_y  = cur_y;
        r.prev_x = path ? prev_x  : '0;
        r.prev_y = path ? prev_y  : '0;
        r.org_x  = path ? start_x : '0;
        r.org_y  = path ? start_y : '0;
        r.last   = 1'b0;
        return r;
    endfunction

    task automatic predict_gestures(input pointer_event_t ev);
        gesture_event_t run[$];
        gesture_event_t r;
        int cls, hc;
        cls = single_class(ev.button);
        case (ev.cmd)
            CMD_PRESS: begin
                cur_x = ev.x;
                cur_y = ev.y;
                if (held == '0) begin
                    start_x = cur_x;
                    start_y = cur_y;
                    prev_x  = cur_x;
                    prev_y  = cur_y;
                end
                held[ev.button] = 1'b1;
                if (cls >= 0) run.push_back(make_result(EV_DOWN, cls, ev.mods, 1'b0));
            end
            CMD_DBL: begin
                cur_x = ev.x;
                cur_y = ev.y;
                if (cls >= 0) run.push_back(make_result(EV_DBL_CLICK, cls, ev.mods, 1'b0));
                dragging = 1'b0;
                held     = '0;
            end
            CMD_MOTION: begin
                prev_x = cur_x;
                prev_y = cur_y;
                cur_x  = ev.x;
                cur_y  = ev.y;
                if (dragging) begin
                    hc = held_class();
                    if (hc >= 0) run.push_back(make_result(EV_DRAG, hc, ev.mods, 1'b1));
                end else if (held != '0) begin
                    if (beyond_threshold()) begin
                        dragging = 1'b1;
                        hc = held_class();
                        if (hc >= 0)
                            run.push_back(make_result(EV_START_DRAG, hc, ev.mods, 1'b0));
                    end
                end else begin
                    run.push_back(make_result(EV_MOVE, int'(CLS_LEFT), ev.mods, 1'b0));
                end
            end
            default: begin
                cur_x = ev.x;
                cur_y = ev.y;
                if (cls >= 0) run.push_back(make_result(EV_UP, cls, ev.mods, 1'b0));
                if (held != '0) begin
                    if (dragging) begin
                        hc = held_class();
                        if (hc >= 0) run.push_back(make_result(EV_END_DRAG, hc, ev.mods, 1'b1));
                        dragging = 1'b0;
                    end else if (cls >= 0) begin
                        run.push_back(make_result(EV_CLICK, cls, ev.mods, 1'b0));
                    end
                    held = '0;
                end
            end
        endcase
        for (int i = 0; i < run.size(); i++) begin
            r = run[i];
            r.last = (i == run.size() - 1);
            expected_events.push_back(r);
        end
    endtask

    // ------------------------------------------------------------------- driver
    always @(posedge aclk) begin : driver
        pointer_event_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_gestures(offered_event);
                accepted_count++;
            end
            if (s_tvalid && !s_tready)
                input_stall_cnt++;
            if (!s_tvalid || s_tready) begin
                if (pending_pointer_events.size() != 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_pointer_events.pop_front();
                    offered_event <= nxt;
                    s_tvalid      <= 1'b1;
                    s_tdata       <= {nxt.y, nxt.x, nxt.mods, nxt.button};
                    s_tuser       <= nxt.cmd;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------ monitor
    task automatic check_field(input string name, input logic [CW-1:0] exp_v,
                               input logic [CW-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        gesture_event_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_events.size() == 0) begin
                $display("%0t: unexpected result transfer, expected none, got kind %0d data %0h",
                         $time, m_tuser, m_tdata);
                error_count++;
            end else begin
                exp_r = expected_events.pop_front();
                check_field("event_kind",      CW'(exp_r.kind),   CW'(m_tuser));
                check_field("button_class",    CW'(exp_r.cls),    CW'(m_tdata[1:0]));
                check_field("event_modifiers", CW'(exp_r.mods),   CW'(m_tdata[14:2]));
                check_field("cur_x",           exp_r.cur_x,       m_tdata[30:15]);
                check_field("cur_y",           exp_r.cur_y,       m_tdata[46:31]);
                check_field("prev_x",          exp_r.prev_x,      m_tdata[62:47]);
                check_field("prev_y",          exp_r.prev_y,      m_tdata[78:63]);
                check_field("origin_x",        exp_r.org_x,       m_tdata[94:79]);
                check_field("origin_y",        exp_r.org_y,       m_tdata[110:95]);
                check_field("last_of_run",     CW'(exp_r.last),   CW'(m_tlast));
                checked_count++;
            end
        end
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= !rx_held && ($urandom_range(99) >= recv_stall_pct);
    end

    // The long receiver hold-off is timed here, independently of the stimulus.
    always @(posedge aclk) begin
        if (long_hold_armed && !long_hold_done) begin
            if (hold_cycles == LONG_HOLD)
                long_hold_done <= 1'b1;
            else
                hold_cycles <= hold_cycles + 1;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, expected_events.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus
    task automatic queue_event(input logic [1:0] cmd, input logic [BTN_W-1:0] b,
                               input logic [MODS_W-1:0] mods,
                               input logic [CW-1:0] x, input logic [CW-1:0] y);
        pointer_event_t ev;
        ev.cmd    = cmd;
        ev.button = b;
        ev.mods   = mods;
        ev.x      = x;
        ev.y      = y;
        pending_pointer_events.push_back(ev);
        queued_count++;
    endtask

    function automatic logic [BTN_W-1:0] pick_button();
        if ($urandom_range(99) < 80)
            return BTN_W'($urandom_range(BTN_RIGHT, BTN_LEFT));
        return BTN_W'($urandom_range(7));
    endfunction

    task automatic step_pointer(input int span);
        if ($urandom_range(15) == 0) begin
            gx = CW'($urandom);
            gy = CW'($urandom);
        end else begin
            gx = CW'(int'(gx) + int'($urandom_range(2 * span)) - span);
            gy = CW'(int'(gy) + int'($urandom_range(2 * span)) - span);
        end
    endtask

    // Mostly well-formed press / motion / release sequences with random content.
    task automatic queue_random_gesture();
        logic [BTN_W-1:0] b;
        int span, r;
        r    = $urandom_range(99);
        span = int'(drag_dist) / 2 + 3;
        if (r < 12) begin
            queue_event(2'($urandom), BTN_W'($urandom), MODS_W'($urandom),
                        CW'($urandom), CW'($urandom));
            return;
        end
        if ($urandom_range(3) == 0) begin
            gx = CW'($urandom);
            gy = CW'($urandom);
        end
        if ($urandom_range(4) == 0) begin
            repeat ($urandom_range(3, 1)) begin
                step_pointer(span);
                queue_event(CMD_MOTION, BTN_W'($urandom), MODS_W'($urandom), gx, gy);
            end
        end
        b = pick_button();
        queue_event(CMD_PRESS, b, MODS_W'($urandom), gx, gy);
        if ($urandom_range(3) == 0)
            queue_event(CMD_PRESS, pick_button(), MODS_W'($urandom), gx, gy);
        repeat ($urandom_range(6)) begin
            step_pointer(span);
            queue_event(CMD_MOTION, BTN_W'($urandom), MODS_W'($urandom), gx, gy);
        end
        r = $urandom_range(99);
        if (r < 65)
            queue_event(CMD_RELEASE, b, MODS_W'($urandom), gx, gy);
        else if (r < 78)
            queue_event(CMD_RELEASE, pick_button(), MODS_W'($urandom), gx, gy);
        else if (r < 90)
            queue_event(CMD_DBL, pick_button(), MODS_W'($urandom), gx, gy);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_pointer_events.size() != 0 || s_tvalid || expected_events.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic run_phase(input logic [DIST_W-1:0] threshold, input int send_idle,
                             input int recv_stall, input int n_items, input logic hold);
        int target;
        apb_write(3'(REG_DRAG_DISTANCE) << 2, 32'(threshold));
        @(negedge aclk);
        drag_dist      = threshold;
        send_idle_pct  = send_idle;
        recv_stall_pct = recv_stall;
        if (hold)
            long_hold_armed = 1'b1;
        target = queued_count + n_items;
        while (queued_count < target)
            queue_random_gesture();
        wait_idle();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part at the reset threshold of 4.
        send_idle_pct  = 19;
        recv_stall_pct = 19;
        queue_event(CMD_MOTION,  3'd0,      13'h0000, 16'sd0,   16'sd0);
        queue_event(CMD_PRESS,   BTN_LEFT,  13'h1FFF, 16'sd100, 16'sd100);
        queue_event(CMD_MOTION,  3'd0,      13'h0155, 16'sd103, 16'sd102);
        // Exactly on the threshold: no drag yet.
        queue_event(CMD_MOTION,  3'd0,      13'h0AAA, 16'sd104, 16'sd100);
        queue_event(CMD_MOTION,  3'd7,      13'h1234, 16'sd104, 16'sd101);
        queue_event(CMD_MOTION,  3'd0,      13'h0F0F, 16'sd110, 16'sd110);
        queue_event(CMD_PRESS,   BTN_RIGHT, 13'h0001, 16'sd111, 16'sd112);
        queue_event(CMD_MOTION,  3'd0,      13'h1000, 16'sd120, 16'sd90);
        queue_event(CMD_RELEASE, BTN_RIGHT, 13'h1FFF, 16'sd121, 16'sd91);
        // Release with nothing held gives up only.
        queue_event(CMD_RELEASE, BTN_LEFT,  13'h0000, 16'sd122, 16'sd92);
        queue_event(CMD_PRESS,   BTN_MID,   13'h0002, 16'sh7FFF, 16'sh8000);
        queue_event(CMD_MOTION,  3'd0,      13'h0004, 16'sh8000, 16'sh7FFF);
        queue_event(CMD_RELEASE, BTN_MID,   13'h0008, 16'sh8000, 16'sh7FFF);
        // Untracked button: state moves but drag results stay silent.
        queue_event(CMD_PRESS,   3'd5,      13'h0010, 16'sd0,    16'sd0);
        queue_event(CMD_MOTION,  3'd0,      13'h0020, 16'sd300,  -16'sd300);
        queue_event(CMD_MOTION,  3'd0,      13'h0040, 16'sd301,  -16'sd301);
        queue_event(CMD_RELEASE, 3'd5,      13'h0080, 16'sd302,  -16'sd302);
        // Repeated press of a held button, then release of one that is not held.
        queue_event(CMD_PRESS,   BTN_LEFT,  13'h0100, -16'sd5,   -16'sd5);
        queue_event(CMD_PRESS,   BTN_LEFT,  13'h0200, -16'sd6,   -16'sd6);
        queue_event(CMD_RELEASE, BTN_MID,   13'h0400, -16'sd7,   -16'sd7);
        queue_event(CMD_PRESS,   3'd7,      13'h0800, 16'sd50,   16'sd50);
        queue_event(CMD_PRESS,   BTN_RIGHT, 13'h1555, 16'sd51,   16'sd51);
        queue_event(CMD_RELEASE, 3'd6,      13'h0AAA, 16'sd52,   16'sd52);
        queue_event(CMD_PRESS,   BTN_LEFT,  13'h1FFE, 16'sd9,    16'sd9);
        queue_event(CMD_DBL,     BTN_LEFT,  13'h0001, 16'sd9,    16'sd9);
        queue_event(CMD_DBL,     3'd0,      13'h1FFF, 16'sh7FFF, 16'sh7FFF);
        queue_event(CMD_RELEASE, 3'd4,      13'h0000, 16'sh8000, 16'sh8000);
        wait_idle();

        run_phase(8'd0,   0,  0,  200, 1'b0);
        run_phase(8'd255, 84, 0,  200, 1'b0);
        run_phase(8'd1,   0,  84, 200, 1'b0);
        run_phase(DIST_W'($urandom), 19, 19, 200, 1'b0);
        run_phase(8'd8,   0,  0,  150, 1'b1);
        run_phase(8'd4,   19, 19, 300, 1'b0);

        $display("Checked %0d gesture results from %0d pointer events, drag distance 0 to 255.",
                 checked_count, accepted_count);
        $display("Input held off for %0d cycles under result-side back-pressure.",
                 input_stall_cnt);
        if (error_count == 0 && expected_events.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
